// File: sv/lsac_pkg.sv
package lsac_pkg;

	// Array size and the index width that addresses it.
	localparam int SENSORS = 8;
	localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

	// Field widths.
	localparam int RAW_W = 12;
	localparam int LEVEL_W = 10;
	localparam int WEIGHT_W = 7;
	localparam int POS_W = 15;
	localparam int WTOT_W = 28;
	localparam int LTOT_W = 14;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;

	// Multiplier operand and product widths.
	localparam int MUL_A_W = 12;
	localparam int MUL_B_W = 14;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Divider widths: dividend and quotient share one word, two bits per cycle.
	localparam int DIV_N_W = 28;
	localparam int DIV_D_W = 14;
	localparam int DIV_STEPS = DIV_N_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [LEVEL_W-1:0] FULL_SCALE = 10'd1000;
	localparam logic [RAW_W-1:0] RAW_MAX = 12'd4095;
	localparam logic [WEIGHT_W-1:0] PERCENT = 7'd100;
	localparam logic [WTOT_W-1:0] WTOT_MAX = 28'hFFF_FFFF;
	localparam logic [LTOT_W-1:0] LTOT_MAX = 14'h3FFF;
	localparam logic [POS_W-1:0] POS_MAX = 15'd15000;
	localparam logic [POS_W-1:0] POS_NONE = 15'h7FFF;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_CALIBRATE = 2'd1,
		CMD_MEASURE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_DARK = 2'd0,
		KIND_LIGHT = 2'd1,
		KIND_UNSURE = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_READS_HIGH = 3'd0,
		REG_FOLLOW_DARK = 3'd1,
		REG_SMOOTH_WEIGHT = 3'd2,
		REG_DETECT_ON = 3'd3,
		REG_DETECT_OFF = 3'd4,
		REG_SURFACE_MARGIN = 3'd5
	} reg_idx_t;

	// Status of the shared divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Sensor index times 1000, the weight of a sensor in the centroid.
	function automatic logic [MUL_B_W-1:0] pos_weight(input logic [3:0] idx);
		logic [MUL_B_W-1:0] w;
		w = MUL_B_W'(idx) * MUL_B_W'(FULL_SCALE);
		return w;
	endfunction

	// Surface class from the dark and light scores of a smoothed value.
	function automatic kind_t classify(input logic [LEVEL_W-1:0] s,
			input logic [LEVEL_W-1:0] margin);
		logic [LEVEL_W:0] dark;
		logic [LEVEL_W:0] light;
		kind_t k;
		dark = {1'b0, s};
		light = {1'b0, FULL_SCALE - s};
		if (dark >= light + {1'b0, margin}) begin
			k = KIND_DARK;
		end else if (light >= dark + {1'b0, margin}) begin
			k = KIND_LIGHT;
		end else begin
			k = KIND_UNSURE;
		end
		return k;
	endfunction

endpackage

// File: sv/lsac_div.sv
// Restoring divider that retires two quotient bits per cycle. The dividend
// register shifts left and collects the quotient in its low bits.
module lsac_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [lsac_pkg::DIV_N_W-1:0] dividend,
	input logic [lsac_pkg::DIV_D_W-1:0] divisor,
	output lsac_pkg::div_stat_t stat,
	output logic [lsac_pkg::DIV_N_W-1:0] quotient
);

	logic [lsac_pkg::DIV_N_W-1:0] num_q;
	logic [lsac_pkg::DIV_D_W-1:0] den_q;
	logic [lsac_pkg::DIV_D_W-1:0] rem_q;
	logic [lsac_pkg::DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [lsac_pkg::DIV_D_W:0] r1;
	logic [lsac_pkg::DIV_D_W:0] r1_sub;
	logic [lsac_pkg::DIV_D_W-1:0] r1_keep;
	logic [lsac_pkg::DIV_D_W:0] r2;
	logic [lsac_pkg::DIV_D_W:0] r2_sub;
	logic [lsac_pkg::DIV_D_W-1:0] r2_keep;
	logic ge1;
	logic ge2;

	always_comb begin
		r1 = {rem_q, num_q[lsac_pkg::DIV_N_W-1]};
		ge1 = r1 >= {1'b0, den_q};
		r1_sub = r1 - {1'b0, den_q};
		r1_keep = ge1 ? r1_sub[lsac_pkg::DIV_D_W-1:0] : r1[lsac_pkg::DIV_D_W-1:0];
		r2 = {r1_keep, num_q[lsac_pkg::DIV_N_W-2]};
		ge2 = r2 >= {1'b0, den_q};
		r2_sub = r2 - {1'b0, den_q};
		r2_keep = ge2 ? r2_sub[lsac_pkg::DIV_D_W-1:0] : r2[lsac_pkg::DIV_D_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start
				&& (cnt_q == lsac_pkg::DIV_CNT_W'(lsac_pkg::DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == lsac_pkg::DIV_CNT_W'(lsac_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[lsac_pkg::DIV_N_W-3:0], ge1, ge2};
			rem_q <= r2_keep;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = num_q;

endmodule

// File: sv/line_sensor_array_calibrator.sv
// Reflectance sensor array calibrator and line locator.
// Words enter on the s_axis channel, one per sensor reading: tuser carries the
// command (clear, calibrate, measure), tdata the sensor number and raw level,
// tlast marks the last reading of a frame. Clear and calibrate give no output
// word; every measure gives one word on m_axis with the smoothed level, the
// surface class in tuser and, on the frame's last word (tlast), the line flag
// and the centroid position (sensor number times 1000, all ones when none).
// The block works on one word at a time and drops s_axis_tready meanwhile.
// A measure makes up to three passes through the shared radix-4 divider (range
// scaling, percent smoothing, centroid). The result word is presented in the
// same cycle in which the input becomes ready again.
// The result sits in an output register, so the next word is accepted while
// the receiver stalls; only a second result waits for the first to be taken.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Reset clears the calibration window to empty, the smoothed
// levels to zero, the frame sums and flags, and loads the register defaults;
// no word is pending at the output after reset.
module line_sensor_array_calibrator (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// [3:0] sensor number, [15:4] raw_level
	input logic [15:0] s_axis_tdata,
	// [1:0] command
	input logic [1:0] s_axis_tuser,
	input logic s_axis_tlast,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [9:0] scaled_level, [10] line_found, [25:11] line_position, [31:26] zero
	output logic [31:0] m_axis_tdata,
	// [1:0] surface_kind
	output logic [1:0] m_axis_tuser,
	output logic m_axis_tlast,
	input logic cfg_we,
	input logic [lsac_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lsac_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Sequencer states, one hot.
	typedef enum logic [14:0] {
		ST_IDLE = 15'h0001,
		ST_DISPATCH = 15'h0002,
		ST_SC_MUL = 15'h0004,
		ST_SC_GO = 15'h0008,
		ST_SC_WAIT = 15'h0010,
		ST_SM_MUL1 = 15'h0020,
		ST_SM_MUL2 = 15'h0040,
		ST_SM_GO = 15'h0080,
		ST_SM_WAIT = 15'h0100,
		ST_ACC_MUL = 15'h0200,
		ST_ACC_ADD = 15'h0400,
		ST_FRAME = 15'h0800,
		ST_POS_GO = 15'h1000,
		ST_POS_WAIT = 15'h2000,
		ST_EMIT = 15'h4000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic line_reads_high_q;
	logic follow_dark_q;
	logic [lsac_pkg::WEIGHT_W-1:0] weight_q;
	logic [lsac_pkg::LEVEL_W-1:0] on_level_q;
	logic [lsac_pkg::LEVEL_W-1:0] off_level_q;
	logic [lsac_pkg::LEVEL_W-1:0] margin_q;

	// Per-sensor calibration and smoothing state.
	logic [lsac_pkg::RAW_W-1:0] low_q [lsac_pkg::SENSORS];
	logic [lsac_pkg::RAW_W-1:0] high_q [lsac_pkg::SENSORS];
	logic [lsac_pkg::LEVEL_W-1:0] smooth_q [lsac_pkg::SENSORS];

	// Frame state.
	logic primed_q;
	logic line_q;
	logic [lsac_pkg::WTOT_W-1:0] wtot_q;
	logic [lsac_pkg::LTOT_W-1:0] ltot_q;
	logic [lsac_pkg::LEVEL_W-1:0] peak_q;

	// Latched input word.
	lsac_pkg::cmd_t cmd_q;
	logic [3:0] idx_q;
	logic [lsac_pkg::RAW_W-1:0] raw_q;
	logic last_q;

	// Working registers.
	logic [lsac_pkg::MUL_P_W-1:0] prod_q;
	logic [lsac_pkg::MUL_P_W-1:0] sum_q;
	logic [lsac_pkg::LEVEL_W-1:0] inst_q;
	logic [lsac_pkg::LEVEL_W-1:0] sm_q;

	// Result fields, then the output register.
	logic [lsac_pkg::LEVEL_W-1:0] scaled_q;
	lsac_pkg::kind_t kind_q;
	logic found_q;
	logic [lsac_pkg::POS_W-1:0] pos_q;
	logic out_valid_q;
	logic [31:0] out_data_q;
	logic [1:0] out_user_q;
	logic out_last_q;

	// Shared arithmetic.
	logic [lsac_pkg::MUL_A_W-1:0] mul_a;
	logic [lsac_pkg::MUL_B_W-1:0] mul_b;
	logic [lsac_pkg::MUL_P_W-1:0] mul_p;
	logic div_start;
	logic [lsac_pkg::DIV_N_W-1:0] div_num;
	logic [lsac_pkg::DIV_D_W-1:0] div_den;
	lsac_pkg::div_stat_t div_stat;
	logic [lsac_pkg::DIV_N_W-1:0] div_q;

	logic [lsac_pkg::IDX_W-1:0] sidx;
	logic in_range;
	logic [lsac_pkg::RAW_W-1:0] lo_cur;
	logic [lsac_pkg::RAW_W-1:0] hi_cur;
	logic window_ok;
	logic [lsac_pkg::WEIGHT_W-1:0] w_eff;
	logic [lsac_pkg::LEVEL_W-1:0] v_sel;
	logic [lsac_pkg::LEVEL_W-1:0] inst_c;
	logic [lsac_pkg::LEVEL_W-1:0] target;
	logic [lsac_pkg::WTOT_W:0] wtot_sum;
	logic [lsac_pkg::LTOT_W:0] ltot_sum;
	logic line_next;
	logic accept;
	logic out_free;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_axis_tready;

	assign sidx = idx_q[lsac_pkg::IDX_W-1:0];
	assign in_range = {1'b0, idx_q} < 5'(lsac_pkg::SENSORS);
	assign lo_cur = low_q[sidx];
	assign hi_cur = high_q[sidx];
	assign window_ok = (hi_cur > lo_cur) && (raw_q > lo_cur);
	assign w_eff = (weight_q > lsac_pkg::PERCENT) ? lsac_pkg::PERCENT : weight_q;

	// Instant value: the clamped scaling quotient, or zero for an empty window or
	// a raw level not above the low end, inverted when the line reads low.
	always_comb begin
		v_sel = '0;
		if (state_q == ST_SC_WAIT) begin
			if (div_q > lsac_pkg::DIV_N_W'(lsac_pkg::FULL_SCALE)) begin
				v_sel = lsac_pkg::FULL_SCALE;
			end else begin
				v_sel = div_q[lsac_pkg::LEVEL_W-1:0];
			end
		end
		inst_c = line_reads_high_q ? v_sel : lsac_pkg::FULL_SCALE - v_sel;
	end

	assign target = follow_dark_q ? sm_q : lsac_pkg::FULL_SCALE - sm_q;
	assign wtot_sum = {1'b0, wtot_q} + (lsac_pkg::WTOT_W + 1)'(prod_q);
	assign ltot_sum = {1'b0, ltot_q} + (lsac_pkg::LTOT_W + 1)'(target);
	assign line_next = line_q ? (peak_q >= off_level_q) : (peak_q >= on_level_q);

	// Operand selection for the single multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SC_MUL: begin
				mul_a = raw_q - lo_cur;
				mul_b = lsac_pkg::MUL_B_W'(lsac_pkg::FULL_SCALE);
			end
			ST_SM_MUL1: begin
				mul_a = lsac_pkg::MUL_A_W'(smooth_q[sidx]);
				mul_b = lsac_pkg::MUL_B_W'(lsac_pkg::PERCENT - w_eff);
			end
			ST_SM_MUL2: begin
				mul_a = lsac_pkg::MUL_A_W'(inst_q);
				mul_b = lsac_pkg::MUL_B_W'(w_eff);
			end
			ST_ACC_MUL: begin
				mul_a = lsac_pkg::MUL_A_W'(target);
				mul_b = lsac_pkg::pos_weight(idx_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = lsac_pkg::MUL_P_W'(mul_a) * lsac_pkg::MUL_P_W'(mul_b);

	// Operand selection for the shared divider.
	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		case (state_q)
			ST_SC_GO: begin
				div_start = 1'b1;
				div_num = lsac_pkg::DIV_N_W'(prod_q);
				div_den = lsac_pkg::DIV_D_W'(hi_cur - lo_cur);
			end
			ST_SM_GO: begin
				div_start = 1'b1;
				div_num = lsac_pkg::DIV_N_W'(sum_q) + lsac_pkg::DIV_N_W'(prod_q);
				div_den = lsac_pkg::DIV_D_W'(lsac_pkg::PERCENT);
			end
			ST_POS_GO: begin
				div_start = 1'b1;
				div_num = wtot_q;
				div_den = ltot_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	lsac_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_num),
		.divisor(div_den),
		.stat(div_stat),
		.quotient(div_q)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_reads_high_q <= 1'b1;
			follow_dark_q <= 1'b1;
			weight_q <= 7'd30;
			on_level_q <= 10'd300;
			off_level_q <= 10'd200;
			margin_q <= 10'd200;
		end else if (cfg_we) begin
			case (cfg_index)
				lsac_pkg::REG_LINE_READS_HIGH: line_reads_high_q <= cfg_data[0];
				lsac_pkg::REG_FOLLOW_DARK: follow_dark_q <= cfg_data[0];
				lsac_pkg::REG_SMOOTH_WEIGHT: weight_q <= cfg_data[lsac_pkg::WEIGHT_W-1:0];
				lsac_pkg::REG_DETECT_ON: on_level_q <= cfg_data;
				lsac_pkg::REG_DETECT_OFF: off_level_q <= cfg_data;
				lsac_pkg::REG_SURFACE_MARGIN: margin_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and the state it owns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < lsac_pkg::SENSORS; i++) begin
				low_q[i] <= lsac_pkg::RAW_MAX;
				high_q[i] <= '0;
				smooth_q[i] <= '0;
			end
			primed_q <= 1'b0;
			line_q <= 1'b0;
			wtot_q <= '0;
			ltot_q <= '0;
			peak_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register loads as the old word leaves or when it is empty.
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					case (cmd_q)
						lsac_pkg::CMD_CLEAR: begin
							for (int i = 0; i < lsac_pkg::SENSORS; i++) begin
								low_q[i] <= lsac_pkg::RAW_MAX;
								high_q[i] <= '0;
							end
							primed_q <= 1'b0;
							line_q <= 1'b0;
							wtot_q <= '0;
							ltot_q <= '0;
							peak_q <= '0;
							state_q <= ST_IDLE;
						end
						lsac_pkg::CMD_CALIBRATE: begin
							if (in_range) begin
								if (raw_q < lo_cur) begin
									low_q[sidx] <= raw_q;
								end
								if (raw_q > hi_cur) begin
									high_q[sidx] <= raw_q;
								end
							end
							state_q <= ST_IDLE;
						end
						lsac_pkg::CMD_MEASURE: begin
							state_q <= in_range ? ST_SC_MUL : ST_FRAME;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SC_MUL: begin
					if (window_ok) begin
						state_q <= ST_SC_GO;
					end else if (primed_q) begin
						state_q <= ST_SM_MUL1;
					end else begin
						state_q <= ST_ACC_MUL;
					end
				end
				ST_SC_GO: begin
					state_q <= ST_SC_WAIT;
				end
				ST_SC_WAIT: begin
					if (div_stat.done) begin
						state_q <= primed_q ? ST_SM_MUL1 : ST_ACC_MUL;
					end
				end
				ST_SM_MUL1: begin
					state_q <= ST_SM_MUL2;
				end
				ST_SM_MUL2: begin
					state_q <= ST_SM_GO;
				end
				ST_SM_GO: begin
					state_q <= ST_SM_WAIT;
				end
				ST_SM_WAIT: begin
					if (div_stat.done) begin
						state_q <= ST_ACC_MUL;
					end
				end
				ST_ACC_MUL: begin
					smooth_q[sidx] <= sm_q;
					state_q <= ST_ACC_ADD;
				end
				ST_ACC_ADD: begin
					// Both frame sums saturate rather than wrap.
					wtot_q <= wtot_sum[lsac_pkg::WTOT_W] ? lsac_pkg::WTOT_MAX
						: wtot_sum[lsac_pkg::WTOT_W-1:0];
					ltot_q <= ltot_sum[lsac_pkg::LTOT_W] ? lsac_pkg::LTOT_MAX
						: ltot_sum[lsac_pkg::LTOT_W-1:0];
					if (target > peak_q) begin
						peak_q <= target;
					end
					state_q <= ST_FRAME;
				end
				ST_FRAME: begin
					if (last_q) begin
						primed_q <= 1'b1;
						line_q <= line_next;
						if (line_next && (ltot_q != '0)) begin
							state_q <= ST_POS_GO;
						end else begin
							wtot_q <= '0;
							ltot_q <= '0;
							peak_q <= '0;
							state_q <= ST_EMIT;
						end
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_POS_GO: begin
					// The divider has latched the sums, so the frame restarts here.
					wtot_q <= '0;
					ltot_q <= '0;
					peak_q <= '0;
					state_q <= ST_POS_WAIT;
				end
				ST_POS_WAIT: begin
					if (div_stat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Data registers; the sequencer state decides when each one loads.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= lsac_pkg::cmd_t'(s_axis_tuser);
			idx_q <= s_axis_tdata[3:0];
			raw_q <= s_axis_tdata[15:4];
			last_q <= s_axis_tlast;
		end
		case (state_q)
			ST_DISPATCH: begin
				scaled_q <= '0;
				kind_q <= lsac_pkg::KIND_UNSURE;
				found_q <= 1'b0;
				pos_q <= lsac_pkg::POS_NONE;
			end
			ST_SC_MUL: begin
				prod_q <= mul_p;
				inst_q <= inst_c;
				sm_q <= inst_c;
			end
			ST_SC_WAIT: begin
				inst_q <= inst_c;
				sm_q <= inst_c;
			end
			ST_SM_MUL1: begin
				sum_q <= mul_p;
			end
			ST_SM_MUL2: begin
				prod_q <= mul_p;
			end
			ST_SM_WAIT: begin
				sm_q <= div_q[lsac_pkg::LEVEL_W-1:0];
			end
			ST_ACC_MUL: begin
				prod_q <= mul_p;
				scaled_q <= sm_q;
				kind_q <= lsac_pkg::classify(sm_q, margin_q);
			end
			ST_FRAME: begin
				found_q <= last_q && line_next;
			end
			ST_POS_WAIT: begin
				if (div_q > lsac_pkg::DIV_N_W'(lsac_pkg::POS_MAX)) begin
					pos_q <= lsac_pkg::POS_MAX;
				end else begin
					pos_q <= div_q[lsac_pkg::POS_W-1:0];
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_data_q <= {6'd0, pos_q, found_q, scaled_q};
					out_user_q <= kind_q;
					out_last_q <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_user_q;
	assign m_axis_tlast = out_last_q;

	// An accepted word always moves the sequencer out of idle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input still ready after a word was accepted");

	// The divider reports completion only while the sequencer waits for it.
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_SC_WAIT || state_q == ST_SM_WAIT
			|| state_q == ST_POS_WAIT))
		else $error("divider finished with nobody waiting");

	// Words that do not close a frame carry no line result.
	a_mid_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (!m_axis_tdata[10]
			&& m_axis_tdata[25:11] == lsac_pkg::POS_NONE))
		else $error("line fields set on a word inside a frame");

	// A reported position is either the none code or at most POS_MAX (15000).
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[25:11] == lsac_pkg::POS_NONE
			|| m_axis_tdata[25:11] <= lsac_pkg::POS_MAX))
		else $error("line position out of range");

endmodule
